// File: rtl/jitter_buffer_playout_control_defines.svh
// Assertion macros for the jitter buffer playout control block.
`ifndef JITTER_BUFFER_PLAYOUT_CONTROL_DEFINES_SVH
`define JITTER_BUFFER_PLAYOUT_CONTROL_DEFINES_SVH
`ifndef SYNTHESIS
`define JB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define JB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/jbpc_pkg.sv
// Package with types and constants for the jitter buffer playout control block.
`timescale 1ns / 1ps
package jbpc_pkg;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  localparam logic [3:0] ACT_SILENCE  = 4'd0;
  localparam logic [3:0] ACT_NORMAL   = 4'd1;
  localparam logic [3:0] ACT_FEC      = 4'd2;
  localparam logic [3:0] ACT_PLC      = 4'd3;
  localparam logic [3:0] ACT_RESYNC   = 4'd4;
  localparam logic [3:0] ACT_UNDERRUN = 4'd5;
  localparam logic [3:0] ACT_ACCEPT   = 4'd6;
  localparam logic [3:0] ACT_LATE     = 4'd7;
  localparam logic [3:0] ACT_DUP      = 4'd8;
  localparam logic [3:0] ACT_RELEASE  = 4'd9;

  localparam logic [1:0] REG_PREBUF = 2'd0;
  localparam logic [1:0] REG_PLCMAX = 2'd1;
  localparam logic [1:0] REG_RESYNC = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [15:0] seq;
    logic [7:0]  payload_handle;
    logic [10:0] payload_length;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  out_handle;
    logic [10:0] out_length;
    logic [15:0] out_seq;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  handle;
    logic [10:0] length;
  } entry_t;

  // Shift-line control shared by all cells
  typedef struct packed {
    logic           ins;     // write new entry at ins_idx, shift upper entries up
    logic [IdxW-1:0] ins_idx;
    logic           pop;     // shift all entries down by one
    entry_t         new_ent;
  } cell_ctl_t;

  // Signed-style wrap test: true when b lies before a
  function automatic logic dist_neg(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = b - a;
    return d[15];
  endfunction
endpackage

// File: rtl/jbpc_cell.sv
// One queue cell: holds one entry, loads from its lower or upper neighbor.
`timescale 1ns / 1ps
module jbpc_cell (
  input  logic                 clk,
  input  logic [jbpc_pkg::IdxW-1:0] my_idx,
  input  jbpc_pkg::cell_ctl_t  ctl,
  input  jbpc_pkg::entry_t     from_lo,
  input  jbpc_pkg::entry_t     from_hi,
  output jbpc_pkg::entry_t     ent
);
  import jbpc_pkg::*;
  entry_t ent_r, ent_nxt;

  // Pick new content: shift down on pop, open a slot on insert
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.pop) begin
      ent_nxt = from_hi;
    end else if (ctl.ins) begin
      if (my_idx == ctl.ins_idx) begin
        ent_nxt = ctl.new_ent;
      end else if (my_idx > ctl.ins_idx) begin
        ent_nxt = from_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;
endmodule

// File: rtl/jbpc_chain.sv
// Row of queue cells forming the sorted shift line.
`timescale 1ns / 1ps
module jbpc_chain (
  input  logic                clk,
  input  jbpc_pkg::cell_ctl_t ctl,
  input  logic [jbpc_pkg::IdxW-1:0] rd_idx,
  output jbpc_pkg::entry_t    front,
  output jbpc_pkg::entry_t    rd_ent
);
  import jbpc_pkg::*;
  entry_t ents [QueueDepth];

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    entry_t lo, hi;
    if (g == 0) begin : g_lo0
      assign lo = ents[0];
    end else begin : g_lo
      assign lo = ents[g-1];
    end
    if (g == QueueDepth - 1) begin : g_hiN
      assign hi = ents[g];
    end else begin : g_hi
      assign hi = ents[g+1];
    end
    jbpc_cell u_cell (
      .clk     (clk),
      .my_idx  (IdxW'(g)),
      .ctl     (ctl),
      .from_lo (lo),
      .from_hi (hi),
      .ent     (ents[g])
    );
  end

  assign front  = ents[0];
  assign rd_ent = ents[rd_idx];
endmodule

// File: rtl/jitter_buffer_playout_control.sv
// Top level of the jitter buffer playout control block.
// Usage:
//   in_valid/in_ready/in_data carry pushes (kind 0) and playout ticks (kind 1).
//   out_valid/out_ready/out_data carry result items; last marks the final one.
//   cfg_we/cfg_idx/cfg_wdata write prebuffer, concealment limit and resync gap
//   while the block is idle.
// Sequencing: one item at a time. A push scans the queue from its tail one
//   entry a cycle while the result register is free, then inserts, releasing
//   the front first when the queue is full; a tick primes if needed and then
//   sweeps stale front entries one per cycle, one transfer each, while the
//   result register is free.
// Reset: the queue is emptied by clearing its count, the playout clock and
//   prebuffer state clear, registers return to 3, 5 and 50; queue entries are
//   left as they are since only entries below the count are read.
// Stall: when out_ready is low the result register holds and the control
//   sequencer waits; no new input is taken until the last result transfers.
`timescale 1ns / 1ps
`include "jitter_buffer_playout_control_defines.svh"
module jitter_buffer_playout_control (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jbpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jbpc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [14:0]         cfg_wdata
);
  import jbpc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_PUSH  = 6'b000100,
    S_TICK  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  in_item_t        item_r, item_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [15:0]     owed_r, owed_nxt;
  logic            base_r, base_nxt;
  logic            primed_r, primed_nxt;
  logic [7:0]      erun_r, erun_nxt;
  logic [4:0]      prebuf_r;
  logic [7:0]      plcmax_r;
  logic [14:0]     rgap_r;
  logic [CntW-1:0] scan_r, scan_nxt;    // candidate insert position
  logic            evict_r, evict_nxt;  // front already released for this item
  out_item_t       obuf_r, obuf_nxt;
  logic            ovld_r, ovld_nxt;
  cell_ctl_t       ctl;
  entry_t          front, rd_ent;
  logic [IdxW-1:0] rd_idx;

  jbpc_chain u_chain (
    .clk    (clk),
    .ctl    (ctl),
    .rd_idx (rd_idx),
    .front  (front),
    .rd_ent (rd_ent)
  );

  assign rd_idx = (scan_r == '0) ? '0 : IdxW'(scan_r - 1'b1);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovld_r;
  assign out_data  = obuf_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prebuf_r <= 5'd3;
      plcmax_r <= 8'd5;
      rgap_r   <= 15'd50;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PREBUF: prebuf_r <= cfg_wdata[4:0];
        REG_PLCMAX: plcmax_r <= cfg_wdata[7:0];
        REG_RESYNC: rgap_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic out_item_t mk(input logic [3:0] a, input entry_t e, input logic l);
    out_item_t o;
    o.action = a;
    o.out_handle = e.handle;
    o.out_length = e.length;
    o.out_seq = e.seq;
    o.last = l;
    return o;
  endfunction

  // Sequencer
  always_comb begin
    entry_t    pe, zero_e;
    logic [7:0]  er_inc;
    logic [15:0] gap;
    logic [4:0]  need;
    logic        out_free;
    state_nxt = state_r;
    item_nxt  = item_r;
    count_nxt = count_r;
    owed_nxt  = owed_r;
    base_nxt  = base_r;
    primed_nxt = primed_r;
    erun_nxt  = erun_r;
    scan_nxt  = scan_r;
    evict_nxt = evict_r;
    obuf_nxt  = obuf_r;
    ovld_nxt  = ovld_r;
    ctl       = '0;
    pe.seq    = item_r.seq;
    pe.handle = item_r.payload_handle;
    pe.length = item_r.payload_length;
    zero_e    = '0;
    ctl.new_ent = pe;
    er_inc    = (erun_r == 8'hFF) ? erun_r : erun_r + 8'd1;
    gap       = front.seq - owed_r;
    need      = (prebuf_r == 5'd0) ? 5'd1 : prebuf_r;
    out_free  = !ovld_r || out_ready;
    if (ovld_r && out_ready) ovld_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          evict_nxt = 1'b0;
          if (in_data.kind) begin
            state_nxt = S_TICK;
          end else begin
            if (!base_r) begin
              owed_nxt = in_data.seq;
              base_nxt = 1'b1;
            end
            scan_nxt = count_r;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Late test, then walk down from the tail, one cell per unstalled cycle
        if (out_free) begin
          if (dist_neg(owed_r, item_r.seq)) begin
            obuf_nxt = mk(ACT_LATE, pe, 1'b1);
            ovld_nxt = 1'b1;
            state_nxt = S_WAIT;
          end else if (scan_r == '0) begin
            state_nxt = S_PUSH;
          end else if (rd_ent.seq == item_r.seq) begin
            obuf_nxt = mk(ACT_DUP, pe, 1'b1);
            ovld_nxt = 1'b1;
            state_nxt = S_WAIT;
          end else if (!dist_neg(rd_ent.seq, item_r.seq)) begin
            state_nxt = S_PUSH;
          end else begin
            scan_nxt = scan_r - 1'b1;
          end
        end
      end
      S_PUSH: begin
        if (out_free) begin
          if (!evict_r && count_r == CntW'(QueueDepth)) begin
            // Release the oldest entry first
            obuf_nxt = mk(ACT_RELEASE, front, 1'b0);
            ovld_nxt = 1'b1;
            ctl.pop = 1'b1;
            count_nxt = count_r - 1'b1;
            evict_nxt = 1'b1;
            if (scan_r != '0) scan_nxt = scan_r - 1'b1;
          end else begin
            ctl.ins = 1'b1;
            ctl.ins_idx = IdxW'(scan_r);
            count_nxt = count_r + 1'b1;
            erun_nxt = '0;
            obuf_nxt = mk(ACT_ACCEPT, pe, 1'b1);
            ovld_nxt = 1'b1;
            state_nxt = S_WAIT;
          end
        end
      end
      S_TICK: begin
        if (out_free) begin
          if (!primed_r && count_r < CntW'(need)) begin
            obuf_nxt = mk(ACT_SILENCE, zero_e, 1'b1);
            ovld_nxt = 1'b1;
            state_nxt = S_WAIT;
          end else if (!primed_r) begin
            primed_nxt = 1'b1;
            owed_nxt = front.seq;
          end else if (count_r == '0 && !evict_r) begin
            erun_nxt = er_inc;
            if (er_inc <= plcmax_r) begin
              owed_nxt = owed_r + 16'd1;
              obuf_nxt = mk(ACT_PLC, zero_e, 1'b1);
            end else begin
              primed_nxt = 1'b0;
              base_nxt = 1'b0;
              obuf_nxt = mk(ACT_UNDERRUN, zero_e, 1'b1);
            end
            ovld_nxt = 1'b1;
            state_nxt = S_WAIT;
          end else if (count_r == '0) begin
            // Sweep emptied the queue
            erun_nxt = er_inc;
            owed_nxt = owed_r + 16'd1;
            obuf_nxt = mk(ACT_PLC, zero_e, 1'b1);
            ovld_nxt = 1'b1;
            state_nxt = S_WAIT;
          end else if (gap[15]) begin
            obuf_nxt = mk(ACT_RELEASE, front, 1'b0);
            ovld_nxt = 1'b1;
            ctl.pop = 1'b1;
            count_nxt = count_r - 1'b1;
            evict_nxt = 1'b1;
          end else if (gap >= {1'b0, rgap_r} || gap == 16'd0) begin
            obuf_nxt = mk((gap == 16'd0 && !(gap >= {1'b0, rgap_r})) ? ACT_NORMAL
                          : ACT_RESYNC, front, 1'b1);
            ovld_nxt = 1'b1;
            owed_nxt = front.seq + 16'd1;
            ctl.pop = 1'b1;
            count_nxt = count_r - 1'b1;
            erun_nxt = '0;
            state_nxt = S_WAIT;
          end else if (gap == 16'd1) begin
            obuf_nxt = mk(ACT_FEC, front, 1'b1);
            ovld_nxt = 1'b1;
            owed_nxt = owed_r + 16'd1;
            erun_nxt = '0;
            state_nxt = S_WAIT;
          end else begin
            erun_nxt = er_inc;
            ovld_nxt = 1'b1;
            state_nxt = S_WAIT;
            if (er_inc > plcmax_r) begin
              obuf_nxt = mk(ACT_RESYNC, front, 1'b1);
              owed_nxt = front.seq + 16'd1;
              ctl.pop = 1'b1;
              count_nxt = count_r - 1'b1;
              erun_nxt = '0;
            end else begin
              owed_nxt = owed_r + 16'd1;
              obuf_nxt = mk(ACT_PLC, zero_e, 1'b1);
            end
          end
        end
      end
      S_EMIT: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        // Drain the final result before taking the next item
        if (!ovld_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      owed_r   <= '0;
      base_r   <= 1'b0;
      primed_r <= 1'b0;
      erun_r   <= '0;
      ovld_r   <= 1'b0;
      evict_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      owed_r   <= owed_nxt;
      base_r   <= base_nxt;
      primed_r <= primed_nxt;
      erun_r   <= erun_nxt;
      ovld_r   <= ovld_nxt;
      evict_r  <= evict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    scan_r <= scan_nxt;
    obuf_r <= obuf_nxt;
  end

  `JB_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CntW'(QueueDepth))
  `JB_ASSERT_IMPL(a_busy_no_take, clk, rst_n, state_r != S_IDLE, !in_ready)
  `JB_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `JB_ASSERT_NEXT(a_stall_data, clk, rst_n, out_valid && !out_ready, $stable(out_data))
endmodule

// File: tb/jitter_buffer_playout_control_test.sv
// Testbench for the jitter buffer playout control block: directed and random traffic.
`timescale 1ns / 1ps
module jitter_buffer_playout_control_test;
  import jbpc_pkg::*;

  // Register index outside the list, written to check that it is ignored
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [14:0] cfg_wdata;

  jitter_buffer_playout_control uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Predicted block state
  entry_t      slot_q[$];
  logic [15:0] owed;
  logic        base_ok;
  logic        playing;
  logic [7:0]  miss_run;
  logic [4:0]  prebuf_reg;
  logic [7:0]  plc_reg;
  logic [14:0] gap_reg;

  out_item_t   expected_results[$];
  out_item_t   step_out[$];
  int          fail_count;
  int          cycle_count;
  bit          idle_free;
  logic [15:0] seq_base;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("** jitter_buffer_playout_control: FAILED **");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  function automatic logic is_behind(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = b - a;
    return d[15];
  endfunction

  task automatic emit(input logic [3:0] act, input entry_t e);
    out_item_t r;
    r.action = act;
    r.out_handle = e.handle;
    r.out_length = e.length;
    r.out_seq = e.seq;
    r.last = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic emit_blank(input logic [3:0] act);
    entry_t z;
    z = '0;
    emit(act, z);
  endtask

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'd255) ? v : v + 8'd1;
  endfunction

  // Predict the results of a packet arrival
  task automatic predict_push(input entry_t e);
    int idx;
    logic [15:0] d;
    if (!base_ok) begin
      owed = e.seq;
      base_ok = 1'b1;
    end
    if (is_behind(owed, e.seq)) begin
      emit(ACT_LATE, e);
      return;
    end
    idx = slot_q.size();
    for (int i = slot_q.size(); i > 0; i--) begin
      d = e.seq - slot_q[i-1].seq;
      if (d == 16'd0) begin
        emit(ACT_DUP, e);
        return;
      end
      if (!d[15]) begin
        idx = i;
        break;
      end
      idx = i - 1;
    end
    if (slot_q.size() >= QueueDepth) begin
      emit(ACT_RELEASE, slot_q[0]);
      slot_q.delete(0);
      if (idx > 0) idx--;
    end
    slot_q.insert(idx, e);
    miss_run = 8'd0;
    emit(ACT_ACCEPT, e);
  endtask

  // Predict the results of a playout tick
  task automatic predict_tick();
    int need;
    logic [15:0] gap;
    bit snapped;
    snapped = 0;
    if (!playing) begin
      need = (prebuf_reg == 0) ? 1 : prebuf_reg;
      if (slot_q.size() < need) begin
        emit_blank(ACT_SILENCE);
        return;
      end
      playing = 1'b1;
      owed = slot_q[0].seq;
    end
    if (slot_q.size() == 0) begin
      miss_run = sat_inc(miss_run);
      if (miss_run <= plc_reg) begin
        owed++;
        emit_blank(ACT_PLC);
      end else begin
        playing = 1'b0;
        base_ok = 1'b0;
        emit_blank(ACT_UNDERRUN);
      end
      return;
    end
    while (slot_q.size() > 0 && is_behind(owed, slot_q[0].seq)) begin
      emit(ACT_RELEASE, slot_q[0]);
      slot_q.delete(0);
    end
    if (slot_q.size() == 0) begin
      miss_run = sat_inc(miss_run);
      owed++;
      emit_blank(ACT_PLC);
      return;
    end
    gap = slot_q[0].seq - owed;
    if (gap >= {1'b0, gap_reg}) begin
      owed = slot_q[0].seq;
      gap = 0;
      snapped = 1;
    end
    if (gap == 0) begin
      emit(snapped ? ACT_RESYNC : ACT_NORMAL, slot_q[0]);
      owed = slot_q[0].seq + 16'd1;
      slot_q.delete(0);
      miss_run = 8'd0;
    end else if (gap == 1) begin
      emit(ACT_FEC, slot_q[0]);
      owed++;
      miss_run = 8'd0;
    end else begin
      miss_run = sat_inc(miss_run);
      if (miss_run > plc_reg) begin
        emit(ACT_RESYNC, slot_q[0]);
        owed = slot_q[0].seq + 16'd1;
        slot_q.delete(0);
        miss_run = 8'd0;
      end else begin
        owed++;
        emit_blank(ACT_PLC);
      end
    end
  endtask

  // Drive one item, wait for its transfer, queue its predicted results
  task automatic send_item(input in_item_t it);
    while (!idle_free && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_out.delete();
    if (it.kind) predict_tick();
    else predict_push({it.seq, it.payload_handle, it.payload_length});
    step_out[step_out.size()-1].last = 1'b1;
    foreach (step_out[i]) expected_results.push_back(step_out[i]);
  endtask

  task automatic push_pkt(input logic [15:0] s, input logic [7:0] h, input logic [10:0] l);
    send_item({1'b0, s, h, l});
  endtask

  task automatic tick();
    send_item({1'b1, 16'($urandom), 8'($urandom), 11'($urandom)});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Write a register while idle
  task automatic set_reg(input logic [1:0] idx, input logic [14:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PREBUF: prebuf_reg = val[4:0];
      REG_PLCMAX: plc_reg = val[7:0];
      REG_RESYNC: gap_reg = val;
      default: ;
    endcase
  endtask

  // Random receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= idle_free || ($urandom_range(99) >= 37);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result %h", out_data));
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_data.action !== want.action)
          report($sformatf("action %0d, want %0d", out_data.action, want.action));
        if (out_data.out_handle !== want.out_handle)
          report($sformatf("handle %h, want %h", out_data.out_handle, want.out_handle));
        if (out_data.out_length !== want.out_length)
          report($sformatf("length %h, want %h", out_data.out_length, want.out_length));
        if (out_data.out_seq !== want.out_seq)
          report($sformatf("seq %h, want %h", out_data.out_seq, want.out_seq));
        if (out_data.last !== want.last)
          report($sformatf("last %b, want %b", out_data.last, want.last));
      end
    end
  end

  // Edge values, wrap, duplicates, late packets, underrun, overflow
  task automatic test_directed();
    push_pkt(16'hfffe, 8'hff, 11'h7ff);
    push_pkt(16'hfffe, 8'h00, 11'h000);
    push_pkt(16'h0000, 8'h5a, 11'h2a5);
    push_pkt(16'hffff, 8'ha5, 11'h55a);
    push_pkt(16'hfff0, 8'h01, 11'h001);
    tick();
    tick();
    tick();
    tick();
    tick();
    tick();
    tick();
    push_pkt(16'h0004, 8'h10, 11'h100);
    tick();
    tick();
    for (int i = 0; i < 18; i++) push_pkt(16'h0100 + 16'(i), 8'(i), 11'(i * 3));
    tick();
    for (int i = 0; i < 8; i++) tick();
  endtask

  // Concealment limits, resync gaps and prebuffer depths at their extremes
  task automatic test_registers();
    set_reg(REG_PLCMAX, 15'd0);
    set_reg(REG_RESYNC, 15'd2);
    set_reg(REG_PREBUF, 15'd1);
    push_pkt(16'h0200, 8'h11, 11'h11);
    tick();
    tick();
    push_pkt(16'h0210, 8'h12, 11'h12);
    tick();
    tick();
    tick();
    set_reg(REG_PREBUF, 15'd0);
    set_reg(REG_PLCMAX, 15'd255);
    set_reg(REG_RESYNC, 15'h7fff);
    push_pkt(16'h8000, 8'h21, 11'h21);
    tick();
    push_pkt(16'h8010, 8'h22, 11'h22);
    repeat (20) tick();
    set_reg(REG_PREBUF, 15'd31);
    push_pkt(16'h9000, 8'h30, 11'h30);
    tick();
    set_reg(REG_PREBUF, 15'd16);
    set_reg(REG_SPARE, 15'h7fff);
    set_reg(REG_PLCMAX, 15'd254);
    set_reg(REG_RESYNC, 15'd0);
    tick();
    set_reg(REG_RESYNC, 15'd1);
    tick();
  endtask

  // Mostly ordered streams with reorder, loss and duplicates; some noise
  task automatic test_random(input int count);
    logic [15:0] s;
    int n;
    n = 0;
    while (n < count) begin
      if (n % 120 == 0) begin
        set_reg(REG_PREBUF, 15'($urandom_range(1, 6)));
        set_reg(REG_PLCMAX, 15'($urandom_range(0, 8)));
        set_reg(REG_RESYNC, 15'($urandom_range(2, 40)));
        idle_free = (n % 240 == 120);
      end
      if ($urandom_range(99) < 45) begin
        tick();
      end else begin
        case ($urandom_range(9))
          0: s = 16'($urandom);
          1: s = seq_base - 16'($urandom_range(1, 4));
          2: s = seq_base + 16'($urandom_range(20, 60));
          default: s = seq_base + 16'($urandom_range(0, 3));
        endcase
        if ($urandom_range(3) != 0) seq_base = seq_base + 16'($urandom_range(1, 2));
        push_pkt(s, 8'($urandom), 11'($urandom));
      end
      n++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    fail_count = 0;
    cycle_count = 0;
    idle_free = 0;
    seq_base = 16'hff00;
    owed = '0;
    base_ok = 0;
    playing = 0;
    miss_run = '0;
    prebuf_reg = 5'd3;
    plc_reg = 8'd5;
    gap_reg = 15'd50;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_registers();
    test_random(420);
    drain();
    if (fail_count == 0) $display("** jitter_buffer_playout_control: PASSED **");
    else $display("** jitter_buffer_playout_control: FAILED **");
    $finish;
  end
endmodule
